// File: sv/owtr_pkg.sv
// Package for the 1-Wire temperature reader: phase codes, register indexes,
// register defaults, response type and the command byte and conversion helpers.
// No dependencies.
package owtr_pkg;

   localparam int unsigned TICK_W = 20;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DATA_W = 20;
   localparam int unsigned TEMP_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRE_RESET_HIGH = 3'd0,
      CSR_RESET_LOW      = 3'd1,
      CSR_PRESENCE_WAIT  = 3'd2,
      CSR_RESET_RECOVER  = 3'd3,
      CSR_SLOT_EDGE      = 3'd4,
      CSR_READ_SAMPLE    = 3'd5,
      CSR_SLOT_HOLD      = 3'd6,
      CSR_CONVERT_WAIT   = 3'd7
   } csr_index_type;

   localparam logic [7:0]        DEF_PRE_RESET_HIGH = 8'd2;
   localparam logic [11:0]       DEF_RESET_LOW      = 12'd500;
   localparam logic [9:0]        DEF_PRESENCE_WAIT  = 10'd60;
   localparam logic [11:0]       DEF_RESET_RECOVER  = 12'd420;
   localparam logic [7:0]        DEF_SLOT_EDGE      = 8'd4;
   localparam logic [7:0]        DEF_READ_SAMPLE    = 8'd1;
   localparam logic [9:0]        DEF_SLOT_HOLD      = 10'd60;
   localparam logic [TICK_W-1:0] DEF_CONVERT_WAIT   = 20'd800000;

   localparam logic [7:0]        CMD_SKIP_ROM   = 8'hCC;
   localparam logic [7:0]        CMD_CONVERT    = 8'h44;
   localparam logic [7:0]        CMD_READ_PAD   = 8'hBE;
   localparam logic [TEMP_W-1:0] TEMP_FAIL      = 16'hFFFF;
   localparam logic [TEMP_W-1:0] TEMP_NEG_LIMIT = 16'h0FFF;
   localparam logic [TEMP_W-1:0] TEMP_SIGN      = 16'h8000;

   localparam logic [2:0] STEP_CONVERT = 3'd2;
   localparam logic [2:0] STEP_READ_LO = 3'd4;
   localparam logic [2:0] STEP_READ_HI = 3'd5;

   typedef enum logic [12:0] {
      PH_IDLE        = 13'b0000000000001,
      PH_RST_HIGH    = 13'b0000000000010,
      PH_RST_LOW     = 13'b0000000000100,
      PH_RST_WAIT    = 13'b0000000001000,
      PH_RST_RECOVER = 13'b0000000010000,
      PH_WR_HIGH     = 13'b0000000100000,
      PH_WR_LOW      = 13'b0000001000000,
      PH_WR_BIT      = 13'b0000010000000,
      PH_RD_HIGH     = 13'b0000100000000,
      PH_RD_LOW      = 13'b0001000000000,
      PH_RD_WAIT     = 13'b0010000000000,
      PH_RD_HOLD     = 13'b0100000000000,
      PH_CONVERT     = 13'b1000000000000
   } phase_type;

   typedef struct packed {
      logic              drive_enable;
      logic              drive_level;
      logic              busy_res;
      logic              done_res;
      logic              fail;
      logic [TEMP_W-1:0] temperature;
   } rsp_type;

   // skip-ROM, convert, skip-ROM, read scratchpad
   function automatic logic [7:0] cmd_byte(input logic [1:0] step);
      logic [7:0] b;
      case (step)
         2'd0:    b = CMD_SKIP_ROM;
         2'd1:    b = CMD_CONVERT;
         2'd2:    b = CMD_SKIP_ROM;
         default: b = CMD_READ_PAD;
      endcase
      return b;
   endfunction

   // raw sensor word to sign-magnitude tenths, rounded: (x*5+4)>>3
   function automatic logic [TEMP_W-1:0] convert_word(input logic [TEMP_W-1:0] x);
      logic [TEMP_W-1:0] m;
      logic [TEMP_W+2:0] p;
      logic [TEMP_W-1:0] r;
      m = (x < TEMP_NEG_LIMIT) ? x : (~x + 16'd1);
      p = {1'b0, m, 2'b00} + {3'b000, m} + 19'd4;
      r = p[TEMP_W+2:3];
      if (x >= TEMP_NEG_LIMIT) begin
         r = r | TEMP_SIGN;
      end
      return r;
   endfunction

endpackage

// File: sv/onewire_temperature_reader.sv
// Responses are registered: each accepted request yields one response.
// Throughput: one request per clock. While rsp_stall is high, a skid entry behind
// the output register takes one more request, then req_stall holds off the input.
// Reset: synchronous, active high; phase idle, counters and bytes zero,
// temperature 0xFFFF, timing registers back to their defaults.
// Depends on owtr_pkg.
module onewire_temperature_reader (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_command,
   input  logic                                 req_line_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_drive_enable,
   output logic                                 rsp_drive_level,
   output logic                                 rsp_busy_res,
   output logic                                 rsp_done_res,
   output logic                                 rsp_fail,
   output logic [owtr_pkg::TEMP_W-1:0]          rsp_temperature,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [owtr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [owtr_pkg::CSR_DATA_W-1:0]      csr_data
);

   // timing registers
   logic [7:0]                    pre_high_ff, slot_edge_ff, rd_sample_ff;
   logic [11:0]                   rst_low_ff, rst_recover_ff;
   logic [9:0]                    pres_wait_ff, slot_hold_ff;
   logic [owtr_pkg::TICK_W-1:0]   conv_wait_ff;

   // sequencer state
   owtr_pkg::phase_type           phase_ff, phase_in;
   logic [owtr_pkg::TICK_W-1:0]   tick_ff, tick_in, tick_next, len_raw, phase_len;
   logic [2:0]                    bit_ff, bit_in, step_ff, step_in, step_inc;
   logic [7:0]                    shift_ff, shift_in, low_ff, low_in, wr_byte;
   logic                          presence_ff, presence_in;
   logic [owtr_pkg::TEMP_W-1:0]   result_ff, result_in;

   // output buffer
   logic                          rsp_valid_ff, skid_valid_ff;
   owtr_pkg::rsp_type             rsp_ff, skid_ff, rsp_new;
   logic                          accept, out_free, done, failed;

   assign csr_ready = 1'b1;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_high_ff    <= owtr_pkg::DEF_PRE_RESET_HIGH;
         rst_low_ff     <= owtr_pkg::DEF_RESET_LOW;
         pres_wait_ff   <= owtr_pkg::DEF_PRESENCE_WAIT;
         rst_recover_ff <= owtr_pkg::DEF_RESET_RECOVER;
         slot_edge_ff   <= owtr_pkg::DEF_SLOT_EDGE;
         rd_sample_ff   <= owtr_pkg::DEF_READ_SAMPLE;
         slot_hold_ff   <= owtr_pkg::DEF_SLOT_HOLD;
         conv_wait_ff   <= owtr_pkg::DEF_CONVERT_WAIT;
      end else if (csr_valid && csr_ready) begin
         case (owtr_pkg::csr_index_type'(csr_index))
            owtr_pkg::CSR_PRE_RESET_HIGH: pre_high_ff    <= csr_data[7:0];
            owtr_pkg::CSR_RESET_LOW:      rst_low_ff     <= csr_data[11:0];
            owtr_pkg::CSR_PRESENCE_WAIT:  pres_wait_ff   <= csr_data[9:0];
            owtr_pkg::CSR_RESET_RECOVER:  rst_recover_ff <= csr_data[11:0];
            owtr_pkg::CSR_SLOT_EDGE:      slot_edge_ff   <= csr_data[7:0];
            owtr_pkg::CSR_READ_SAMPLE:    rd_sample_ff   <= csr_data[7:0];
            owtr_pkg::CSR_SLOT_HOLD:      slot_hold_ff   <= csr_data[9:0];
            owtr_pkg::CSR_CONVERT_WAIT:   conv_wait_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // length of the running phase; zero acts as one tick
   always_comb begin
      case (phase_ff)
         owtr_pkg::PH_RST_HIGH:    len_raw = {12'd0, pre_high_ff};
         owtr_pkg::PH_RST_LOW:     len_raw = {8'd0, rst_low_ff};
         owtr_pkg::PH_RST_WAIT:    len_raw = {10'd0, pres_wait_ff};
         owtr_pkg::PH_RST_RECOVER: len_raw = {8'd0, rst_recover_ff};
         owtr_pkg::PH_WR_HIGH,
         owtr_pkg::PH_WR_LOW,
         owtr_pkg::PH_RD_HIGH,
         owtr_pkg::PH_RD_LOW:      len_raw = {12'd0, slot_edge_ff};
         owtr_pkg::PH_RD_WAIT:     len_raw = {12'd0, rd_sample_ff};
         owtr_pkg::PH_WR_BIT,
         owtr_pkg::PH_RD_HOLD:     len_raw = {10'd0, slot_hold_ff};
         owtr_pkg::PH_CONVERT:     len_raw = conv_wait_ff;
         default:                  len_raw = 20'd1;
      endcase
      phase_len = (len_raw == 20'd0) ? 20'd1 : len_raw;
   end

   assign tick_next = tick_ff + 20'd1;
   assign step_inc  = step_ff + 3'd1;

   always_comb begin
      phase_in    = phase_ff;
      tick_in     = tick_ff;
      bit_in      = bit_ff;
      step_in     = step_ff;
      shift_in    = shift_ff;
      low_in      = low_ff;
      presence_in = presence_ff;
      result_in   = result_ff;
      done        = 1'b0;
      failed      = 1'b0;
      if (req_command) begin
         if (phase_ff == owtr_pkg::PH_IDLE) begin
            phase_in    = owtr_pkg::PH_RST_HIGH;
            tick_in     = '0;
            bit_in      = '0;
            step_in     = '0;
            shift_in    = '0;
            low_in      = '0;
            presence_in = 1'b0;
         end
      end else if (phase_ff != owtr_pkg::PH_IDLE) begin
         if (tick_next >= phase_len) begin
            tick_in = '0;
            case (phase_ff)
               owtr_pkg::PH_RST_HIGH: phase_in = owtr_pkg::PH_RST_LOW;
               owtr_pkg::PH_RST_LOW:  phase_in = owtr_pkg::PH_RST_WAIT;
               owtr_pkg::PH_RST_WAIT: begin
                  presence_in = !req_line_in;
                  phase_in    = owtr_pkg::PH_RST_RECOVER;
               end
               owtr_pkg::PH_RST_RECOVER: begin
                  if (presence_ff && req_line_in) begin
                     bit_in   = '0;
                     phase_in = owtr_pkg::PH_WR_HIGH;
                  end else begin
                     result_in = owtr_pkg::TEMP_FAIL;
                     failed    = 1'b1;
                     done      = 1'b1;
                     phase_in  = owtr_pkg::PH_IDLE;
                  end
               end
               owtr_pkg::PH_WR_HIGH: phase_in = owtr_pkg::PH_WR_LOW;
               owtr_pkg::PH_WR_LOW:  phase_in = owtr_pkg::PH_WR_BIT;
               owtr_pkg::PH_WR_BIT: begin
                  if (bit_ff != 3'd7) begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = owtr_pkg::PH_WR_HIGH;
                  end else begin
                     bit_in  = '0;
                     step_in = step_inc;
                     if (step_inc == owtr_pkg::STEP_CONVERT) begin
                        phase_in = owtr_pkg::PH_CONVERT;
                     end else if (step_inc >= owtr_pkg::STEP_READ_LO) begin
                        step_in  = owtr_pkg::STEP_READ_LO;
                        shift_in = '0;
                        phase_in = owtr_pkg::PH_RD_HIGH;
                     end else begin
                        phase_in = owtr_pkg::PH_WR_HIGH;
                     end
                  end
               end
               owtr_pkg::PH_RD_HIGH: phase_in = owtr_pkg::PH_RD_LOW;
               owtr_pkg::PH_RD_LOW:  phase_in = owtr_pkg::PH_RD_WAIT;
               owtr_pkg::PH_RD_WAIT: begin
                  shift_in = {req_line_in, shift_ff[7:1]};
                  phase_in = owtr_pkg::PH_RD_HOLD;
               end
               owtr_pkg::PH_RD_HOLD: begin
                  if (bit_ff != 3'd7) begin
                     bit_in   = bit_ff + 3'd1;
                     phase_in = owtr_pkg::PH_RD_HIGH;
                  end else if (step_ff == owtr_pkg::STEP_READ_LO) begin
                     low_in   = shift_ff;
                     shift_in = '0;
                     bit_in   = '0;
                     step_in  = owtr_pkg::STEP_READ_HI;
                     phase_in = owtr_pkg::PH_RD_HIGH;
                  end else begin
                     result_in = owtr_pkg::convert_word({shift_ff, low_ff});
                     done      = 1'b1;
                     phase_in  = owtr_pkg::PH_IDLE;
                  end
               end
               owtr_pkg::PH_CONVERT: phase_in = owtr_pkg::PH_RST_HIGH;
               default:              phase_in = owtr_pkg::PH_IDLE;
            endcase
         end else begin
            tick_in = tick_next;
         end
      end
   end

   assign wr_byte = owtr_pkg::cmd_byte(step_in[1:0]);

   always_comb begin
      rsp_new.drive_enable = 1'b0;
      rsp_new.drive_level  = 1'b0;
      case (phase_in)
         owtr_pkg::PH_RST_HIGH,
         owtr_pkg::PH_WR_HIGH,
         owtr_pkg::PH_RD_HIGH: begin
            rsp_new.drive_enable = 1'b1;
            rsp_new.drive_level  = 1'b1;
         end
         owtr_pkg::PH_RST_LOW,
         owtr_pkg::PH_WR_LOW,
         owtr_pkg::PH_RD_LOW: begin
            rsp_new.drive_enable = 1'b1;
         end
         owtr_pkg::PH_WR_BIT: begin
            rsp_new.drive_enable = 1'b1;
            rsp_new.drive_level  = wr_byte[bit_in];
         end
         default: ;
      endcase
      rsp_new.busy_res    = (phase_in != owtr_pkg::PH_IDLE);
      rsp_new.done_res    = done;
      rsp_new.fail        = failed;
      rsp_new.temperature = result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= owtr_pkg::PH_IDLE;
         tick_ff     <= '0;
         bit_ff      <= '0;
         step_ff     <= '0;
         shift_ff    <= '0;
         low_ff      <= '0;
         presence_ff <= 1'b0;
         result_ff   <= owtr_pkg::TEMP_FAIL;
      end else if (accept) begin
         phase_ff    <= phase_in;
         tick_ff     <= tick_in;
         bit_ff      <= bit_in;
         step_ff     <= step_in;
         shift_ff    <= shift_in;
         low_ff      <= low_in;
         presence_ff <= presence_in;
         result_ff   <= result_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (accept) begin
            rsp_ff <= rsp_new;
         end
      end else if (accept) begin
         skid_ff <= rsp_new;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_enable = rsp_ff.drive_enable;
   assign rsp_drive_level  = rsp_ff.drive_level;
   assign rsp_busy_res     = rsp_ff.busy_res;
   assign rsp_done_res     = rsp_ff.done_res;
   assign rsp_fail         = rsp_ff.fail;
   assign rsp_temperature  = rsp_ff.temperature;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry held without a valid output entry");

   a_tick_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != owtr_pkg::PH_IDLE) |-> (tick_ff < phase_len))
      else $error("tick counter beyond phase length");

   a_idle_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == owtr_pkg::PH_IDLE) |-> (tick_ff == '0))
      else $error("tick counter not cleared while idle");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= owtr_pkg::STEP_READ_HI)
      else $error("byte step out of range");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted request produced no response");

endmodule

// File: tb/sv/tb.sv
// Testbench for onewire_temperature_reader: an emulated sensor feeds start and tick
// requests, every response is predicted and checked field by field.
// Depends on owtr_pkg and the onewire_temperature_reader RTL.
module tb;

   localparam int WATCHDOG_LIMIT = 2000;

   localparam logic [3:0][7:0] WRITE_BYTES = {owtr_pkg::CMD_READ_PAD, owtr_pkg::CMD_SKIP_ROM,
                                              owtr_pkg::CMD_CONVERT, owtr_pkg::CMD_SKIP_ROM};
   localparam logic [4:0][15:0] CORNER_WORDS = {16'h0000, 16'h0FFE, 16'h0FFF, 16'h1000,
                                                16'hFFFF};

   typedef enum int {FAULT_NONE, FAULT_NO_PRESENCE, FAULT_LINE_LOW} fault_type;

   typedef struct packed {
      logic [7:0]  pre_high;
      logic [11:0] rst_low;
      logic [9:0]  pres_wait;
      logic [11:0] recover;
      logic [7:0]  slot_edge;
      logic [7:0]  rd_sample;
      logic [9:0]  hold;
      logic [19:0] conv;
   } timing_type;

   typedef struct packed {
      owtr_pkg::phase_type ph;
      logic [19:0] tick;
      logic [2:0]  bit_idx;
      logic [2:0]  step;
      logic [7:0]  shift;
      logic [7:0]  lo;
      logic        presence;
      logic [15:0] word;
   } bus_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_command = 1'b0;
   logic req_line_in = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_drive_enable;
   logic rsp_drive_level;
   logic rsp_busy_res;
   logic rsp_done_res;
   logic rsp_fail;
   logic [owtr_pkg::TEMP_W-1:0] rsp_temperature;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [owtr_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [owtr_pkg::CSR_DATA_W-1:0] csr_data = '0;

   timing_type cfg;
   bus_state_type gen_bus;
   bus_state_type model_bus;
   logic [1:0] bus_requests[$];
   owtr_pkg::rsp_type pending_readings[$];
   owtr_pkg::rsp_type next_reading;
   owtr_pkg::rsp_type oldest;
   owtr_pkg::rsp_type seen;
   logic [1:0] next_request;
   int requests_queued = 0;
   int readings_checked = 0;
   int useful = 0;
   int mismatches = 0;
   int quiet_cycles = 0;
   int gap_left = 0;
   int stall_left = 0;
   int press_mark = 300;
   logic req_taken = 1'b0;
   logic req_calm = 1'b0;
   logic rsp_calm = 1'b0;
   logic moved;

   onewire_temperature_reader i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_command(req_command),
      .req_line_in(req_line_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_drive_enable(rsp_drive_enable),
      .rsp_drive_level(rsp_drive_level),
      .rsp_busy_res(rsp_busy_res),
      .rsp_done_res(rsp_done_res),
      .rsp_fail(rsp_fail),
      .rsp_temperature(rsp_temperature),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic timing_type default_timing();
      timing_type t;
      t.pre_high  = owtr_pkg::DEF_PRE_RESET_HIGH;
      t.rst_low   = owtr_pkg::DEF_RESET_LOW;
      t.pres_wait = owtr_pkg::DEF_PRESENCE_WAIT;
      t.recover   = owtr_pkg::DEF_RESET_RECOVER;
      t.slot_edge = owtr_pkg::DEF_SLOT_EDGE;
      t.rd_sample = owtr_pkg::DEF_READ_SAMPLE;
      t.hold      = owtr_pkg::DEF_SLOT_HOLD;
      t.conv      = owtr_pkg::DEF_CONVERT_WAIT;
      return t;
   endfunction

   function automatic bus_state_type idle_bus();
      bus_state_type s;
      s = '0;
      s.ph = owtr_pkg::PH_IDLE;
      s.word = owtr_pkg::TEMP_FAIL;
      return s;
   endfunction

   function automatic logic [20:0] phase_ticks(input owtr_pkg::phase_type ph,
                                               input timing_type t);
      logic [20:0] n;
      case (ph)
         owtr_pkg::PH_RST_HIGH:    n = 21'(t.pre_high);
         owtr_pkg::PH_RST_LOW:     n = 21'(t.rst_low);
         owtr_pkg::PH_RST_WAIT:    n = 21'(t.pres_wait);
         owtr_pkg::PH_RST_RECOVER: n = 21'(t.recover);
         owtr_pkg::PH_WR_HIGH, owtr_pkg::PH_WR_LOW,
         owtr_pkg::PH_RD_HIGH, owtr_pkg::PH_RD_LOW: n = 21'(t.slot_edge);
         owtr_pkg::PH_RD_WAIT:     n = 21'(t.rd_sample);
         owtr_pkg::PH_WR_BIT, owtr_pkg::PH_RD_HOLD: n = 21'(t.hold);
         owtr_pkg::PH_CONVERT:     n = 21'(t.conv);
         default:                  n = 21'd1;
      endcase
      if (n == 21'd0) n = 21'd1;
      return n;
   endfunction

   // sign-magnitude tenths, rounded; the negative branch starts at 0xFFF
   function automatic logic [15:0] to_tenths(input logic [15:0] raw);
      int unsigned m;
      if (raw < owtr_pkg::TEMP_NEG_LIMIT) begin
         m = 32'(raw);
         return 16'((m * 5 + 4) >> 3);
      end
      m = (32'h10000 - 32'(raw)) & 32'hFFFF;
      return 16'((m * 5 + 4) >> 3) | owtr_pkg::TEMP_SIGN;
   endfunction

   task automatic advance_reader(inout bus_state_type s, input timing_type t,
                                 input logic cmd, input logic line,
                                 output owtr_pkg::rsp_type r);
      logic done;
      logic failed;
      done = 1'b0;
      failed = 1'b0;
      if (cmd) begin
         if (s.ph == owtr_pkg::PH_IDLE) begin
            s.ph = owtr_pkg::PH_RST_HIGH;
            s.tick = '0;
            s.bit_idx = '0;
            s.step = '0;
            s.shift = '0;
            s.lo = '0;
            s.presence = 1'b0;
         end
      end else if (s.ph != owtr_pkg::PH_IDLE) begin
         s.tick = s.tick + 20'd1;
         if ({1'b0, s.tick} >= phase_ticks(s.ph, t)) begin
            s.tick = '0;
            case (s.ph)
               owtr_pkg::PH_RST_HIGH: s.ph = owtr_pkg::PH_RST_LOW;
               owtr_pkg::PH_RST_LOW: s.ph = owtr_pkg::PH_RST_WAIT;
               owtr_pkg::PH_RST_WAIT: begin
                  s.presence = !line;
                  s.ph = owtr_pkg::PH_RST_RECOVER;
               end
               owtr_pkg::PH_RST_RECOVER: begin
                  if (s.presence && line) begin
                     s.bit_idx = '0;
                     s.ph = owtr_pkg::PH_WR_HIGH;
                  end else begin
                     s.word = owtr_pkg::TEMP_FAIL;
                     failed = 1'b1;
                     done = 1'b1;
                     s.ph = owtr_pkg::PH_IDLE;
                  end
               end
               owtr_pkg::PH_WR_HIGH: s.ph = owtr_pkg::PH_WR_LOW;
               owtr_pkg::PH_WR_LOW: s.ph = owtr_pkg::PH_WR_BIT;
               owtr_pkg::PH_WR_BIT: begin
                  if (s.bit_idx < 3'd7) begin
                     s.bit_idx = s.bit_idx + 3'd1;
                     s.ph = owtr_pkg::PH_WR_HIGH;
                  end else begin
                     s.bit_idx = '0;
                     s.step = s.step + 3'd1;
                     if (s.step == owtr_pkg::STEP_CONVERT) begin
                        s.ph = owtr_pkg::PH_CONVERT;
                     end else if (s.step >= owtr_pkg::STEP_READ_LO) begin
                        s.step = owtr_pkg::STEP_READ_LO;
                        s.shift = '0;
                        s.ph = owtr_pkg::PH_RD_HIGH;
                     end else begin
                        s.ph = owtr_pkg::PH_WR_HIGH;
                     end
                  end
               end
               owtr_pkg::PH_RD_HIGH: s.ph = owtr_pkg::PH_RD_LOW;
               owtr_pkg::PH_RD_LOW: s.ph = owtr_pkg::PH_RD_WAIT;
               owtr_pkg::PH_RD_WAIT: begin
                  s.shift = {line, s.shift[7:1]};
                  s.ph = owtr_pkg::PH_RD_HOLD;
               end
               owtr_pkg::PH_RD_HOLD: begin
                  if (s.bit_idx < 3'd7) begin
                     s.bit_idx = s.bit_idx + 3'd1;
                     s.ph = owtr_pkg::PH_RD_HIGH;
                  end else if (s.step == owtr_pkg::STEP_READ_LO) begin
                     s.lo = s.shift;
                     s.shift = '0;
                     s.bit_idx = '0;
                     s.step = owtr_pkg::STEP_READ_HI;
                     s.ph = owtr_pkg::PH_RD_HIGH;
                  end else begin
                     s.word = to_tenths({s.shift, s.lo});
                     done = 1'b1;
                     s.ph = owtr_pkg::PH_IDLE;
                  end
               end
               owtr_pkg::PH_CONVERT: s.ph = owtr_pkg::PH_RST_HIGH;
               default: s.ph = owtr_pkg::PH_IDLE;
            endcase
         end
      end
      r = '0;
      case (s.ph)
         owtr_pkg::PH_RST_HIGH, owtr_pkg::PH_WR_HIGH, owtr_pkg::PH_RD_HIGH: begin
            r.drive_enable = 1'b1;
            r.drive_level = 1'b1;
         end
         owtr_pkg::PH_RST_LOW, owtr_pkg::PH_WR_LOW, owtr_pkg::PH_RD_LOW:
            r.drive_enable = 1'b1;
         owtr_pkg::PH_WR_BIT: begin
            r.drive_enable = 1'b1;
            r.drive_level = WRITE_BYTES[s.step[1:0]][s.bit_idx];
         end
         default: ;
      endcase
      r.busy_res = s.ph != owtr_pkg::PH_IDLE;
      r.done_res = done;
      r.fail = done & failed;
      r.temperature = s.word;
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic push_item(input logic cmd, input logic line, output logic fin);
      owtr_pkg::rsp_type r;
      if (!((cmd && gen_bus.ph != owtr_pkg::PH_IDLE) ||
            (!cmd && gen_bus.ph == owtr_pkg::PH_IDLE))) useful++;
      advance_reader(gen_bus, cfg, cmd, line, r);
      bus_requests.push_back({cmd, line});
      requests_queued++;
      fin = r.done_res;
   endtask

   // sensor side: presence pulse, recovery level and data bits at the sample points
   task automatic run_to_done(input logic [15:0] raw, input fault_type fault,
                              input logic late);
      logic fin;
      logic line;
      logic at_fault;
      fin = 1'b0;
      while (!fin) begin
         at_fault = (fault != FAULT_NONE) && ((gen_bus.step != 3'd0) == late);
         line = 1'($urandom);
         case (gen_bus.ph)
            owtr_pkg::PH_RST_WAIT:    line = at_fault && fault == FAULT_NO_PRESENCE;
            owtr_pkg::PH_RST_RECOVER: line = !(at_fault && fault == FAULT_LINE_LOW);
            owtr_pkg::PH_RD_WAIT:
               line = raw[{gen_bus.step == owtr_pkg::STEP_READ_HI, gen_bus.bit_idx}];
            default: ;
         endcase
         if ($urandom_range(0, 39) == 0) push_item(1'b1, 1'($urandom), fin);
         push_item(1'b0, line, fin);
      end
   endtask

   task automatic queue_sequence(input logic [15:0] raw, input fault_type fault,
                                 input logic late);
      logic fin;
      push_item(1'b1, 1'($urandom), fin);
      run_to_done(raw, fault, late);
   endtask

   task automatic drain();
      while (readings_checked != requests_queued) @(negedge clock);
   endtask

   task automatic csr_write(input owtr_pkg::csr_index_type idx,
                            input logic [owtr_pkg::CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_timing(input timing_type t);
      csr_write(owtr_pkg::CSR_PRE_RESET_HIGH, owtr_pkg::CSR_DATA_W'(t.pre_high));
      csr_write(owtr_pkg::CSR_RESET_LOW, owtr_pkg::CSR_DATA_W'(t.rst_low));
      csr_write(owtr_pkg::CSR_PRESENCE_WAIT, owtr_pkg::CSR_DATA_W'(t.pres_wait));
      csr_write(owtr_pkg::CSR_RESET_RECOVER, owtr_pkg::CSR_DATA_W'(t.recover));
      csr_write(owtr_pkg::CSR_SLOT_EDGE, owtr_pkg::CSR_DATA_W'(t.slot_edge));
      csr_write(owtr_pkg::CSR_READ_SAMPLE, owtr_pkg::CSR_DATA_W'(t.rd_sample));
      csr_write(owtr_pkg::CSR_SLOT_HOLD, owtr_pkg::CSR_DATA_W'(t.hold));
      csr_write(owtr_pkg::CSR_CONVERT_WAIT, t.conv);
      cfg = t;
   endtask

   task automatic compare_field(input string name, input int unsigned want,
                                input int unsigned got);
      if (want != got) begin
         $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_command <= 1'b0;
         req_line_in <= 1'b0;
      end else if (!req_valid || req_taken) begin
         req_taken = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (bus_requests.size() != 0) begin
            next_request = bus_requests.pop_front();
            req_command <= next_request[1];
            req_line_in <= next_request[0];
            req_valid <= 1'b1;
            gap_left = req_calm ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
         if ($urandom_range(0, 199) == 0) req_calm = !req_calm;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && readings_checked >= press_mark) begin
            stall_left = 90;
            press_mark = press_mark + 800;
         end else if (stall_left == 0 && !rsp_calm && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
         if ($urandom_range(0, 199) == 0) rsp_calm = !rsp_calm;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            advance_reader(model_bus, cfg, req_command, req_line_in, next_reading);
            pending_readings.push_back(next_reading);
            req_taken = 1'b1;
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen = {rsp_drive_enable, rsp_drive_level, rsp_busy_res, rsp_done_res, rsp_fail,
                    rsp_temperature};
            if (pending_readings.size() == 0) begin
               $display("%0t: response with none expected, temperature expected none, got %h",
                        $time, rsp_temperature);
               mismatches++;
            end else begin
               oldest = pending_readings.pop_front();
               compare_field("drive_enable", 32'(oldest.drive_enable),
                             32'(seen.drive_enable));
               compare_field("drive_level", 32'(oldest.drive_level), 32'(seen.drive_level));
               compare_field("busy_res", 32'(oldest.busy_res), 32'(seen.busy_res));
               compare_field("done_res", 32'(oldest.done_res), 32'(seen.done_res));
               compare_field("fail", 32'(oldest.fail), 32'(seen.fail));
               compare_field("temperature", 32'(oldest.temperature),
                             32'(seen.temperature));
            end
            readings_checked++;
            moved = 1'b1;
         end
         if (csr_valid && csr_ready) moved = 1'b1;
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   initial begin
      timing_type t;
      logic [15:0] raw;
      logic fin;
      fault_type fault;
      int p;
      int k;
      int target;
      cfg = default_timing();
      gen_bus = idle_bus();
      model_bus = idle_bus();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // short reset pulse and recovery; the other timing registers keep their reset values
      csr_write(owtr_pkg::CSR_RESET_LOW, 20'd3);
      csr_write(owtr_pkg::CSR_RESET_RECOVER, 20'd3);
      cfg.rst_low = 12'd3;
      cfg.recover = 12'd3;

      // ticks while idle, start with line high, start while busy
      push_item(1'b0, 1'b0, fin);
      push_item(1'b0, 1'b1, fin);
      push_item(1'b1, 1'b1, fin);
      push_item(1'b1, 1'b0, fin);
      run_to_done(16'h0000, FAULT_NO_PRESENCE, 1'b0);
      queue_sequence(16'h0000, FAULT_LINE_LOW, 1'b0);
      drain();

      t = '0;
      t.rst_low = 12'd1;
      t.pres_wait = 10'd1;
      t.recover = 12'd1;
      t.slot_edge = 8'd1;
      t.hold = 10'd1;
      t.conv = 20'd1;
      set_timing(t);
      for (k = 0; k < 5; k++) queue_sequence(CORNER_WORDS[k], FAULT_NONE, 1'b0);
      queue_sequence(16'h0190, FAULT_LINE_LOW, 1'b0);
      queue_sequence(16'h0190, FAULT_NO_PRESENCE, 1'b1);
      queue_sequence(16'h0190, FAULT_LINE_LOW, 1'b1);
      drain();

      for (p = 0; p < 2; p++) begin
         t.pre_high  = 8'($urandom_range(0, 2));
         t.rst_low   = 12'($urandom_range(1, 2));
         t.pres_wait = 10'($urandom_range(1, 2));
         t.recover   = 12'($urandom_range(1, 2));
         t.slot_edge = 8'($urandom_range(1, 2));
         t.rd_sample = 8'($urandom_range(0, 2));
         t.hold      = 10'($urandom_range(1, 2));
         t.conv      = 20'($urandom_range(1, 8));
         set_timing(t);
         target = useful + 200;
         while (useful < target) begin
            repeat ($urandom_range(0, 3)) push_item(1'b0, 1'($urandom), fin);
            case ($urandom_range(0, 5))
               0: raw = 16'($urandom_range(16'h0FFE, 16'h1000));
               1: raw = 16'($urandom_range(0, 16'h0FFE));
               2: raw = 16'($urandom_range(16'hF000, 16'hFFFF));
               default: raw = 16'($urandom);
            endcase
            k = $urandom_range(0, 9);
            fault = FAULT_NONE;
            if (k == 8) fault = FAULT_NO_PRESENCE;
            else if (k == 9) fault = FAULT_LINE_LOW;
            queue_sequence(raw, fault, 1'($urandom));
         end
         drain();
      end

      repeat (5) @(negedge clock);
      if (pending_readings.size() != 0) begin
         $display("%0t: %0d readings expected, got none", $time, pending_readings.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// File: sim.f
sv/owtr_pkg.sv
sv/onewire_temperature_reader.sv
tb/sv/tb.sv
